/* rtl/ofg_pkg.sv */
package ofg_pkg;

  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned FREQ_W = 22;
  localparam int unsigned IDX_W  = 3;

  // step_percent * max_freq and the quotient by 100 at full width
  localparam int unsigned PROD_W = PCT_W + FREQ_W;
  localparam int unsigned STEP_W = PROD_W - 6;

  // x / 100 == (x * RECIP) >> RECIP_SH, exact for x below 2**PROD_W
  localparam int unsigned RECIP_SH = PROD_W + 7;
  localparam int unsigned RECIP_W  = 30;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(64'd687194768);

  localparam int unsigned STAGES = 3;

  typedef enum logic [IDX_W-1:0] {
    CFG_UP_THR   = 3'd0,
    CFG_DOWN_THR = 3'd1,
    CFG_STEP_PCT = 3'd2,
    CFG_STEP_INT = 3'd3,
    CFG_MAX_FREQ = 3'd4,
    CFG_MIN_FREQ = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [PCT_W-1:0]  load;
    logic [FREQ_W-1:0] cur;
  } item_t;

endpackage

/* rtl/oscillating_freq_governor.sv */
// Oscillating frequency governor. One tick item per cycle is accepted while in_ready is high; the
// result for a tick passes through the alignment stages and the decision stage into the output
// register, and a tick that takes no step, or whose step leaves the request equal to the current
// frequency, gives no result. The step size comes from a multiplier pipeline on step_percent and
// max_freq (prod_r, then step_r) whose settling after a configuration write the alignment stages
// cover. in_ready drops only while a result waits in the output register. The configuration
// port is always ready; writes must go in only while the block is idle, which it does not enforce.
module oscillating_freq_governor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ofg_pkg::PCT_W-1:0]    in_load_percent,
  input  logic [ofg_pkg::FREQ_W-1:0]   in_current_freq,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ofg_pkg::FREQ_W-1:0]   out_target_freq,
  output logic                         out_relation_high,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ofg_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ofg_pkg::FREQ_W-1:0]   cfg_data
);
  import ofg_pkg::*;

  logic [PCT_W-1:0]  up_thr_r, down_thr_r, step_pct_r;
  logic [CNT_W-1:0]  step_int_r;
  logic [FREQ_W-1:0] max_freq_r, min_freq_r;

  logic [PROD_W-1:0]         prod_r;
  logic [FREQ_W-1:0]         max_d_r;
  logic [STEP_W-1:0]         step_r;
  logic [STEP_W-1:0]         step_nxt;
  logic [PROD_W+RECIP_W-1:0] quo_prod;
  logic [FREQ_W+RECIP_W-1:0] quo_max;

  logic [STAGES-1:0] vld_r;
  item_t             item_r [STAGES];

  logic [FREQ_W-1:0] req_r, req_nxt;
  logic              loaded_r;
  logic              going_up_r, going_up_nxt;
  logic [CNT_W-1:0]  tick_r, tick_nxt;

  logic              out_valid_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic              out_rel_r;

  logic              advance;
  item_t             cur_item;
  logic              reload;
  logic [FREQ_W-1:0] req_base;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W:0]    cnt_inc;
  logic              dir;
  logic              do_step;
  logic [FREQ_W+1:0] sum;
  logic [FREQ_W-1:0] diff;
  logic              emit;

  assign cfg_ready         = 1'b1;
  assign advance           = !out_valid_r || out_ready;
  assign in_ready          = advance;
  assign out_valid         = out_valid_r;
  assign out_target_freq   = out_freq_r;
  assign out_relation_high = out_rel_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_thr_r   <= PCT_W'(85);
      down_thr_r <= PCT_W'(15);
      step_pct_r <= PCT_W'(10);
      step_int_r <= CNT_W'(6);
      max_freq_r <= '1;
      min_freq_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UP_THR:   up_thr_r   <= cfg_data[PCT_W-1:0];
        CFG_DOWN_THR: down_thr_r <= cfg_data[PCT_W-1:0];
        CFG_STEP_PCT: step_pct_r <= cfg_data[PCT_W-1:0];
        CFG_STEP_INT: step_int_r <= cfg_data[CNT_W-1:0];
        CFG_MAX_FREQ: max_freq_r <= cfg_data;
        CFG_MIN_FREQ: min_freq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // step size pipeline
  assign quo_prod = (PROD_W+RECIP_W)'(prod_r) * (PROD_W+RECIP_W)'(RECIP);
  assign quo_max  = (FREQ_W+RECIP_W)'(max_d_r) * (FREQ_W+RECIP_W)'(RECIP);

  always_comb begin
    step_nxt = quo_prod[RECIP_SH +: STEP_W];
    if (step_nxt == '0) begin
      step_nxt = STEP_W'(quo_max[RECIP_SH +: (FREQ_W + RECIP_W - RECIP_SH)]);
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(step_pct_r) * PROD_W'(max_freq_r);
    max_d_r <= max_freq_r;
    step_r  <= step_nxt;
  end

  // item alignment stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r[0] <= '{load: in_load_percent, cur: in_current_freq};
      for (int i = 1; i < STAGES; i++) begin
        item_r[i] <= item_r[i-1];
      end
    end
  end

  // decision stage
  always_comb begin
    cur_item = item_r[STAGES-1];
    reload   = !loaded_r || (req_r > max_freq_r) || (req_r < min_freq_r);
    req_base = reload ? cur_item.cur : req_r;
    cnt_base = reload ? step_int_r : tick_r;

    dir = going_up_r;
    if (cur_item.load > up_thr_r) begin
      dir = 1'b1;
    end else if (cur_item.load < down_thr_r) begin
      dir = 1'b0;
    end

    cnt_inc = {1'b0, cnt_base} + (CNT_W+1)'(1);
    do_step = cnt_inc >= {1'b0, step_int_r};
    sum     = {2'b00, req_base} + {1'b0, step_r};
    diff    = min_freq_r;
    if ({1'b0, req_base} > step_r) begin
      diff = req_base - step_r[FREQ_W-1:0];
    end

    req_nxt      = req_base;
    going_up_nxt = dir;
    if (do_step) begin
      if (dir) begin
        if (sum >= {2'b00, max_freq_r}) begin
          req_nxt      = max_freq_r;
          going_up_nxt = 1'b0;
        end else begin
          req_nxt = sum[FREQ_W-1:0];
        end
      end else begin
        if (diff <= min_freq_r) begin
          req_nxt      = min_freq_r;
          going_up_nxt = 1'b1;
        end else begin
          req_nxt = diff;
        end
      end
    end

    tick_nxt = do_step ? '0 : cnt_inc[CNT_W-1:0];
    emit     = do_step && (req_nxt != cur_item.cur);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r      <= '1;
      loaded_r   <= 1'b0;
      going_up_r <= 1'b1;
      tick_r     <= '0;
    end else if (advance && vld_r[STAGES-1]) begin
      req_r      <= req_nxt;
      loaded_r   <= 1'b1;
      going_up_r <= going_up_nxt;
      tick_r     <= tick_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vld_r[STAGES-1] && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && vld_r[STAGES-1] && emit) begin
      out_freq_r <= req_nxt;
      out_rel_r  <= cur_item.load >= up_thr_r;
    end
  end

endmodule

/* rtl/ofg_checker.sv */
module ofg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ofg_pkg::FREQ_W-1:0] out_target_freq,
  input logic                       out_relation_high,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);
  import ofg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target_freq)
      && $stable(out_relation_high))
    else $error("result item changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind oscillating_freq_governor ofg_checker u_ofg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_target_freq   (out_target_freq),
  .out_relation_high (out_relation_high),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready)
);
